/* rtl/spg_pkg.sv */
// shared constants, codes and types of the stepper step pulse generator
// used by the channel interfaces, the divider and the top level

package spg_pkg;

  // motors that drive a direction pin (1 to 4, pins exist for the first four)
  localparam int MOTORS = 4;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int COUNT_W  = 16;
  localparam int TARGET_W = 16;
  localparam int RATE_W   = 16;
  localparam int DIR_W    = 4;
  localparam int POS_W    = 16;
  localparam int NSTEP_W  = 16;
  localparam int TICK_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // divider sizing: operands span a full revolution count plus one
  localparam int DIV_W = 17;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // numerator of the step period: milliseconds per second
  localparam int RATE_NUM = 1000;

  // reset values of the configuration registers
  localparam logic [NSTEP_W-1:0] NUM_STEPS_RST = NSTEP_W'(200);
  localparam logic [TICK_W-1:0]  TICK_MS_RST   = TICK_W'(1);

  // request kinds
  typedef enum logic [FUNC_W-1:0] {
    FN_RISE   = 2'd0,
    FN_FALL   = 2'd1,
    FN_ROTATE = 2'd2,
    FN_MOVE   = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STEPS   = 2'd0,
    CFG_TICK_MS     = 2'd1,
    CFG_INVERT_MASK = 2'd2
  } cfg_idx_t;

  // divider control
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  // direction pins that exist on this build
  function automatic logic [DIR_W-1:0] motor_mask();
    logic [DIR_W-1:0] m;
    for (int i = 0; i < DIR_W; i++) begin
      m[i] = (i < MOTORS);
    end
    return m;
  endfunction

endpackage

/* rtl/spg_if.sv */
// valid/ready channels of the stepper step pulse generator
// depends on spg_pkg for field widths

// request channel: ticks and motion commands
interface spg_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [spg_pkg::FUNC_W-1:0]          func;
  logic                                turn_dir;
  logic [spg_pkg::COUNT_W-1:0]         step_count;
  logic signed [spg_pkg::TARGET_W-1:0] target_step;
  logic [spg_pkg::RATE_W-1:0]          step_rate;

  modport source (output valid, func, turn_dir, step_count, target_step, step_rate,
                  input ready);
  modport sink   (input valid, func, turn_dir, step_count, target_step, step_rate,
                  output ready);
endinterface

// result channel: pin levels and motion status
interface spg_res_if;
  logic                        valid;
  logic                        ready;
  logic                        step_level;
  logic [spg_pkg::DIR_W-1:0]   dir_levels;
  logic [spg_pkg::POS_W-1:0]   position;
  logic                        moving;
  logic                        speed_error;

  modport source (output valid, step_level, dir_levels, position, moving, speed_error,
                  input ready);
  modport sink   (input valid, step_level, dir_levels, position, moving, speed_error,
                  output ready);
endinterface

// configuration write channel
interface spg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spg_pkg::CFG_IDX_W-1:0]   index;
  logic [spg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/spg_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on spg_pkg for operand width and control structs

module spg_div (
  input  logic              clk,
  input  logic              rst,
  input  spg_pkg::div_req_t req,
  output spg_pkg::div_rsp_t rsp
);

  localparam int W = spg_pkg::DIV_W;

  logic [spg_pkg::CNT_W-1:0] cnt;
  logic                      done;
  logic [W-1:0]              dvd;
  logic [W-1:0]              part;
  logic [W-1:0]              dsr;
  logic [W+1:0]              trial;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {1'b0, part, dvd[W-1]} - {2'b0, dsr};

  // iteration count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == spg_pkg::CNT_W'(1));
      if (req.start) begin
        cnt <= spg_pkg::CNT_W'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - spg_pkg::CNT_W'(1);
      end
    end
  end

  // dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      part <= '0;
      dsr  <= req.divisor;
    end else if (cnt != '0) begin
      dvd <= {dvd[W-2:0], ~trial[W+1]};
      if (trial[W+1]) begin
        part <= {part[W-2:0], dvd[W-1]};
      end else begin
        part <= trial[W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = part;

endmodule

/* rtl/stepper_step_pulse_generator.sv */
// Step pulse generator for up to four stepper motors sharing one step pin.
// Requests are rising ticks, falling ticks, rotate-by-count and move-to-step
// commands; each request gives exactly one result. All division and modulo
// work goes through one shared 17-bit restoring divider. A pass runs one
// iteration per quotient bit and ends with a completion pulse, and the
// request port stays low until the current request is done. Divider passes
// run before the result register is loaded:
//  - falling tick, rising tick with no step due, rising tick that steps down
//    from position zero, rotate rejected for speed: no divider pass
//  - rising tick that steps, move-to-step rejected for speed: one pass for
//    the position wrap or the distance
//  - rotate: two passes for the step period
//  - move-to-step: the two passes of rotate and one more pass for the
//    distance modulo the revolution
// A stalled result register holds a finished request until it frees. A
// rejected command, whose speed is below the tick period, changes nothing and
// flags speed_error. A new request is taken while a finished result still
// waits in the result register. Configuration writes are taken in every cycle.
// depends on spg_pkg, spg_if and spg_div

module stepper_step_pulse_generator (
  input  logic      clk,
  input  logic      rst,
  spg_cmd_if.sink   cmd,
  spg_res_if.source res,
  spg_cfg_if.sink   cfg
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_RATE1 = 6'b000100,
    S_RATE2 = 6'b001000,
    S_STEP  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  localparam int W = spg_pkg::DIV_W;

  state_t state;

  // configuration
  logic [spg_pkg::NSTEP_W-1:0] num_steps;
  logic [spg_pkg::TICK_W-1:0]  tick_ms;
  logic [spg_pkg::DIR_W-1:0]   invert_mask;

  // motion state
  logic [spg_pkg::POS_W-1:0]   pos_reg;
  logic [spg_pkg::COUNT_W-1:0] rem_mag;
  logic                        rem_cw;
  logic [spg_pkg::TICK_W-1:0]  period_ticks;
  logic [spg_pkg::POS_W-1:0]   ticks_since_step;
  logic [spg_pkg::DIR_W-1:0]   dir_reg;
  logic                        step_pin;
  logic                        err;

  // request held over the divider passes
  logic [spg_pkg::RATE_W-1:0]  rate_q;
  logic                        diff_neg;

  spg_pkg::div_req_t div_req;
  spg_pkg::div_rsp_t div_rsp;

  spg_pkg::func_t   func;
  logic             cmd_acc;
  logic             res_free;
  logic [W-1:0]     n_eff;
  logic [spg_pkg::TICK_W-1:0] t_eff;
  logic             rate_low_in;
  logic             rate_low_q;
  logic             step_due;
  logic             wrap_low;
  logic [W:0]       diff;
  logic [W-1:0]     diff_abs;
  logic             mod_cw;

  spg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign func     = spg_pkg::func_t'(cmd.func);
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_acc  = cmd.valid && cmd.ready;
  assign res_free = !res.valid || res.ready;

  // zero revolution size means a full 16-bit wrap, zero tick means one
  assign n_eff = (num_steps == '0) ? (W'(1) << spg_pkg::NSTEP_W) : W'(num_steps);
  assign t_eff = (tick_ms == '0) ? spg_pkg::TICK_W'(1) : tick_ms;

  assign rate_low_in = cmd.step_rate < spg_pkg::RATE_W'(t_eff);
  assign rate_low_q  = rate_q < spg_pkg::RATE_W'(t_eff);

  assign step_due = (rem_mag != '0) &&
                    (spg_pkg::POS_W'(period_ticks) <= ticks_since_step);
  assign wrap_low = rem_cw && (pos_reg == '0);

  // signed distance to the target and its magnitude
  assign diff     = (W+1)'(cmd.target_step) - (W+1)'(pos_reg);
  assign diff_abs = diff[W] ? W'(-diff) : diff[W-1:0];
  assign mod_cw   = diff_neg && (div_rsp.rem != '0);

  // divider requests
  always_comb begin
    div_req = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          case (func)
            spg_pkg::FN_RISE: begin
              if (step_due && !wrap_low) begin
                div_req.start    = 1'b1;
                div_req.dividend = rem_cw ? W'(pos_reg) - W'(1) : W'(pos_reg) + W'(1);
                div_req.divisor  = n_eff;
              end
            end
            spg_pkg::FN_ROTATE: begin
              if (!rate_low_in) begin
                div_req.start    = 1'b1;
                div_req.dividend = W'(spg_pkg::RATE_NUM);
                div_req.divisor  = W'(cmd.step_rate);
              end
            end
            spg_pkg::FN_MOVE: begin
              div_req.start    = 1'b1;
              div_req.dividend = diff_abs;
              div_req.divisor  = n_eff;
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        if (div_rsp.done && !rate_low_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = W'(spg_pkg::RATE_NUM);
          div_req.divisor  = W'(rate_q);
        end
      end
      S_RATE1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quot;
          div_req.divisor  = W'(t_eff);
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps   <= spg_pkg::NUM_STEPS_RST;
      tick_ms     <= spg_pkg::TICK_MS_RST;
      invert_mask <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (spg_pkg::cfg_idx_t'(cfg.index))
        spg_pkg::CFG_NUM_STEPS:   num_steps   <= cfg.data[spg_pkg::NSTEP_W-1:0];
        spg_pkg::CFG_TICK_MS:     tick_ms     <= cfg.data[spg_pkg::TICK_W-1:0];
        spg_pkg::CFG_INVERT_MASK: invert_mask <= cfg.data[spg_pkg::DIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      res.valid        <= 1'b0;
      pos_reg          <= '0;
      rem_mag          <= '0;
      rem_cw           <= 1'b0;
      period_ticks     <= '0;
      ticks_since_step <= '0;
      dir_reg          <= '0;
      step_pin         <= 1'b0;
      err              <= 1'b0;
    end else begin
      // result valid: set on a finished request, cleared once taken
      if (state == S_RESP && res_free) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            rate_q <= cmd.step_rate;
            err    <= 1'b0;
            case (func)
              spg_pkg::FN_RISE: begin
                if (step_due) begin
                  step_pin         <= 1'b1;
                  ticks_since_step <= '0;
                  rem_mag          <= rem_mag - spg_pkg::COUNT_W'(1);
                  if (wrap_low) begin
                    pos_reg <= spg_pkg::POS_W'(n_eff - W'(1));
                    state   <= S_RESP;
                  end else begin
                    state <= S_STEP;
                  end
                end else begin
                  if (rem_mag != '0 && ticks_since_step != '1) begin
                    ticks_since_step <= ticks_since_step + spg_pkg::POS_W'(1);
                  end
                  state <= S_RESP;
                end
              end
              spg_pkg::FN_FALL: begin
                step_pin <= 1'b0;
                state    <= S_RESP;
              end
              spg_pkg::FN_ROTATE: begin
                if (rate_low_in) begin
                  err   <= 1'b1;
                  state <= S_RESP;
                end else begin
                  rem_cw  <= cmd.turn_dir;
                  rem_mag <= cmd.step_count;
                  dir_reg <= ({spg_pkg::DIR_W{cmd.turn_dir}} ^ invert_mask) &
                             spg_pkg::motor_mask();
                  state   <= S_RATE1;
                end
              end
              default: begin
                diff_neg <= diff[W];
                state    <= S_MOD;
              end
            endcase
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            if (rate_low_q) begin
              err   <= 1'b1;
              state <= S_RESP;
            end else begin
              rem_cw  <= mod_cw;
              rem_mag <= div_rsp.rem[spg_pkg::COUNT_W-1:0];
              dir_reg <= ({spg_pkg::DIR_W{mod_cw}} ^ invert_mask) & spg_pkg::motor_mask();
              state   <= S_RATE1;
            end
          end
        end
        S_RATE1: begin
          if (div_rsp.done) begin
            state <= S_RATE2;
          end
        end
        S_RATE2: begin
          if (div_rsp.done) begin
            period_ticks     <= div_rsp.quot[spg_pkg::TICK_W-1:0];
            ticks_since_step <= spg_pkg::POS_W'(div_rsp.quot[spg_pkg::TICK_W-1:0]);
            state            <= S_RESP;
          end
        end
        S_STEP: begin
          if (div_rsp.done) begin
            pos_reg <= div_rsp.rem[spg_pkg::POS_W-1:0];
            state   <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_RESP && res_free) begin
      res.step_level  <= step_pin;
      res.dir_levels  <= dir_reg;
      res.position    <= pos_reg;
      res.moving      <= (rem_mag != '0);
      res.speed_error <= err;
    end
  end

endmodule

/* rtl/spg_chk.sv */
// port-level checks of the stepper step pulse generator
// depends on spg_pkg; bound to the top level below

module spg_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic [spg_pkg::FUNC_W-1:0]   cmd_func,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_step_level,
  input logic [spg_pkg::DIR_W-1:0]    res_dir_levels,
  input logic [spg_pkg::POS_W-1:0]    res_position,
  input logic                         res_moving,
  input logic                         res_speed_error
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid && cmd_ready;

  // after reset the block takes requests and holds no result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (cmd_ready && !res_valid))
    else $error("not idle after reset");

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> !cmd_ready)
    else $error("request taken while busy");

  // a falling tick, taken with no result waiting, returns the step pin low
  a_fall_low: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && cmd_func == spg_pkg::FN_FALL && !res_valid) |=> ##1
      (res_valid && !res_step_level && !res_speed_error))
    else $error("falling tick result wrong or late");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_step_level) && $stable(res_dir_levels) &&
       $stable(res_position) && $stable(res_moving) && $stable(res_speed_error)))
    else $error("stalled result changed");

endmodule

bind stepper_step_pulse_generator spg_chk u_spg_chk (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_func        (cmd.func),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_step_level  (res.step_level),
  .res_dir_levels  (res.dir_levels),
  .res_position    (res.position),
  .res_moving      (res.moving),
  .res_speed_error (res.speed_error)
);
